>>> design/ptd_pkg.sv
package ptd_pkg;

	// command codes
	localparam logic [1:0] OP_ADD  = 2'd0;
	localparam logic [1:0] OP_TICK = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	// reply kinds
	localparam logic [2:0] KIND_DISPATCH = 3'd0;
	localparam logic [2:0] KIND_NONE     = 3'd1;
	localparam logic [2:0] KIND_ADDED    = 3'd2;
	localparam logic [2:0] KIND_COUNT    = 3'd3;
	localparam logic [2:0] KIND_REJECT   = 3'd4;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  task_index;
		logic [31:0] task_rate;
	} ptd_in_t;

	typedef struct packed {
		logic [2:0]  reply_kind;
		logic [2:0]  reply_index;
		logic [31:0] run_count;
		logic        last_reply;
	} ptd_out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD,
		ST_READ,
		ST_RPLY,
		ST_T_RD,
		ST_T_CMP,
		ST_T_CNT,
		ST_T_ELA,
		ST_T_END
	} ptd_state_t;

endpackage

>>> design/ptd_ram.sv
module ptd_ram import ptd_pkg::*; #(
	parameter int DEPTH = 8,
	parameter int WIDTH = 32
) (
	input  logic                                 clk,
	input  logic                                 wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                     wr_data,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                     rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

>>> design/periodic_task_dispatcher_core.sv
// add and read each give one reply; the reply is registered in the cycle before the next word is taken.
// tick: each walked slot is read, compared and has its elapsed time updated, and a dispatched
// slot also has its count updated on the one shared 32-bit adder; ST_T_END gives the last reply.
// one word at a time, next taken the cycle after its last reply; a held reply stalls.
// reset: state machine idle, task count zero, run counts read as zero, tick increment 1;
// rate and elapsed tables hold no defined value until written.
module periodic_task_dispatcher_core import ptd_pkg::*; #(
	parameter int MAX_TASKS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  ptd_in_t     in_word,
	output logic        out_valid,
	input  logic        out_ready,
	output ptd_out_t    out_word,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam logic [7:0]    IDX_LIMIT = 8'(MAX_TASKS);
	localparam logic [CW-1:0] CNT_MAX   = CW'(MAX_TASKS);

	ptd_state_t state_q, state_d;

	logic [7:0]        idx_q;
	logic [31:0]       rate_q;
	logic [AW-1:0]     slot_q;
	logic              due_q;
	logic [31:0]       ela_q;
	logic [31:0]       cnt_q;
	logic              pend_valid_q;
	ptd_out_t          pend_q;
	logic [CW-1:0]     active_q;
	logic [15:0]       inc_q;
	logic [MAX_TASKS-1:0] cnt_vld_q;
	logic              cnt_vld_rd_q;
	logic              out_valid_q;
	ptd_out_t          out_q;

	// memory ports
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic          rate_we, ela_we, cnt_we;
	logic [31:0]   ela_wdata;
	logic [31:0]   rate_rd, ela_rd, cnt_rd;
	logic [31:0]   cnt_eff;

	// shared adder
	logic [31:0] alu_a, alu_b, alu_sum;
	logic        alu_cin, alu_co;

	// sequencer controls
	logic     accept;
	logic     push_ok;
	logic     out_load;
	ptd_out_t out_next;
	logic     latch_cmp;
	logic     pend_load, pend_clear;
	ptd_out_t pend_next;
	logic     active_inc;
	logic     slot_inc, slot_clr;
	logic     in_range;
	logic     last_slot;
	logic [2:0] slot3;

	assign in_range  = (idx_q < IDX_LIMIT);
	assign last_slot = ((CW'(slot_q) + CW'(1)) == active_q);
	assign slot3     = 3'(slot_q);
	assign push_ok   = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign cnt_eff   = cnt_vld_rd_q ? cnt_rd : 32'd0;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	// table storage
	ptd_ram #(.DEPTH(MAX_TASKS), .WIDTH(32)) u_rate_ram (
		.clk     (clk),
		.wr_en   (rate_we),
		.wr_addr (wr_addr),
		.wr_data (rate_q),
		.rd_addr (rd_addr),
		.rd_data (rate_rd)
	);

	ptd_ram #(.DEPTH(MAX_TASKS), .WIDTH(32)) u_ela_ram (
		.clk     (clk),
		.wr_en   (ela_we),
		.wr_addr (wr_addr),
		.wr_data (ela_wdata),
		.rd_addr (rd_addr),
		.rd_data (ela_rd)
	);

	ptd_ram #(.DEPTH(MAX_TASKS), .WIDTH(32)) u_cnt_ram (
		.clk     (clk),
		.wr_en   (cnt_we),
		.wr_addr (wr_addr),
		.wr_data (alu_sum),
		.rd_addr (rd_addr),
		.rd_data (cnt_rd)
	);

	// operand selection for the shared adder
	always_comb begin
		alu_a   = 32'd0;
		alu_b   = 32'd0;
		alu_cin = 1'b0;
		unique case (state_q)
			ST_T_CMP: begin
				alu_a   = ela_rd;
				alu_b   = ~rate_rd;
				alu_cin = 1'b1;
			end
			ST_T_CNT: begin
				alu_a   = cnt_q;
				alu_cin = 1'b1;
			end
			ST_T_ELA: begin
				alu_a = due_q ? 32'd0 : ela_q;
				alu_b = 32'(inc_q);
			end
			default: begin
				alu_a = 32'd0;
			end
		endcase
	end

	assign {alu_co, alu_sum} = {1'b0, alu_a} + {1'b0, alu_b} + 33'(alu_cin);

	// sequencer: next state and controls
	always_comb begin
		state_d    = state_q;
		rd_addr    = slot_q;
		wr_addr    = slot_q;
		rate_we    = 1'b0;
		ela_we     = 1'b0;
		cnt_we     = 1'b0;
		ela_wdata  = alu_sum;
		out_load   = 1'b0;
		out_next   = '0;
		latch_cmp  = 1'b0;
		pend_load  = 1'b0;
		pend_clear = 1'b0;
		pend_next  = '0;
		active_inc = 1'b0;
		slot_inc   = 1'b0;
		slot_clr   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					slot_clr = 1'b1;
					case (in_word.opcode)
						OP_ADD:  state_d = ST_ADD;
						OP_READ: state_d = ST_READ;
						OP_TICK: state_d = (active_q == '0) ? ST_T_END : ST_T_RD;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_ADD: begin
				wr_addr   = idx_q[AW-1:0];
				ela_wdata = rate_q;
				if (push_ok) begin
					out_load             = 1'b1;
					out_next.last_reply  = 1'b1;
					out_next.reply_index = idx_q[2:0];
					if (in_range) begin
						rate_we             = 1'b1;
						ela_we              = 1'b1;
						active_inc          = 1'b1;
						out_next.reply_kind = KIND_ADDED;
					end else begin
						out_next.reply_kind = KIND_REJECT;
					end
					state_d = ST_IDLE;
				end
			end
			ST_READ: begin
				rd_addr = idx_q[AW-1:0];
				state_d = ST_RPLY;
			end
			ST_RPLY: begin
				rd_addr = idx_q[AW-1:0];
				if (push_ok) begin
					out_load             = 1'b1;
					out_next.last_reply  = 1'b1;
					out_next.reply_index = idx_q[2:0];
					if (in_range) begin
						out_next.reply_kind = KIND_COUNT;
						out_next.run_count  = cnt_eff;
					end else begin
						out_next.reply_kind = KIND_REJECT;
					end
					state_d = ST_IDLE;
				end
			end
			ST_T_RD: begin
				state_d = ST_T_CMP;
			end
			ST_T_CMP: begin
				latch_cmp = 1'b1;
				state_d   = alu_co ? ST_T_CNT : ST_T_ELA;
			end
			ST_T_CNT: begin
				// a held dispatch word goes out before the new one takes its place
				if (!pend_valid_q || push_ok) begin
					cnt_we               = 1'b1;
					pend_load            = 1'b1;
					pend_next.reply_kind = KIND_DISPATCH;
					pend_next.reply_index = slot3;
					pend_next.run_count  = alu_sum;
					pend_next.last_reply = 1'b0;
					if (pend_valid_q) begin
						out_load = 1'b1;
						out_next = pend_q;
					end
					state_d = ST_T_ELA;
				end
			end
			ST_T_ELA: begin
				ela_we = 1'b1;
				if (last_slot) begin
					state_d = ST_T_END;
				end else begin
					slot_inc = 1'b1;
					state_d  = ST_T_RD;
				end
			end
			ST_T_END: begin
				if (push_ok) begin
					out_load   = 1'b1;
					pend_clear = 1'b1;
					if (pend_valid_q) begin
						out_next = pend_q;
					end else begin
						out_next.reply_kind = KIND_NONE;
					end
					out_next.last_reply = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= '0;
			inc_q        <= 16'd1;
			cnt_vld_q    <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				inc_q <= cfg_data;
			end
			if (active_inc && (active_q != CNT_MAX)) begin
				active_q <= active_q + CW'(1);
			end
			if (cnt_we) begin
				cnt_vld_q[slot_q] <= 1'b1;
			end
			if (pend_load) begin
				pend_valid_q <= 1'b1;
			end else if (pend_clear) begin
				pend_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// slot counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (slot_clr) begin
			slot_q <= '0;
		end else if (slot_inc) begin
			slot_q <= slot_q + AW'(1);
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		cnt_vld_rd_q <= cnt_vld_q[rd_addr];
		if (accept) begin
			idx_q  <= in_word.task_index;
			rate_q <= in_word.task_rate;
		end
		if (latch_cmp) begin
			due_q <= alu_co;
			ela_q <= ela_rd;
			cnt_q <= cnt_eff;
		end
		if (pend_load) begin
			pend_q <= pend_next;
		end
		if (out_load) begin
			out_q <= out_next;
		end
	end

endmodule

>>> test/tb.sv
module tb import ptd_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TASK_SLOTS = 8;
	// longest tick walk plus margin, also covers a dropped spare opcode
	localparam int SETTLE_CYCLES = 4 * TASK_SLOTS + 20;
	localparam logic [1:0] OP_SPARE = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	ptd_in_t     in_word = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	ptd_out_t    out_word;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;

	int err_count = 0;
	int send_idle = 0;
	int recv_idle = 0;
	int stall_request = 0;
	int stall_left = 0;

	// scheduler state as the testbench sees it
	logic [31:0] rate_tab [TASK_SLOTS];
	logic [31:0] elapsed_tab [TASK_SLOTS];
	logic [31:0] runs_tab [TASK_SLOTS];
	bit          slot_written [TASK_SLOTS];
	int          task_total;
	logic [15:0] step_size;
	ptd_out_t    expected_replies [$];

	periodic_task_dispatcher_core #(.MAX_TASKS(TASK_SLOTS)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void queue_reply(input logic [2:0] kind, input logic [2:0] slot,
		input logic [31:0] count);
		ptd_out_t r;
		r.reply_kind  = kind;
		r.reply_index = slot;
		r.run_count   = count;
		r.last_reply  = 1'b0;
		expected_replies.push_back(r);
	endfunction

	// update the task table for one command word and queue the replies it causes
	function automatic void predict_replies(input ptd_in_t w);
		ptd_out_t tail;
		bit due_any;
		case (w.opcode)
			OP_ADD: begin
				if (w.task_index >= TASK_SLOTS) begin
					queue_reply(KIND_REJECT, w.task_index[2:0], '0);
				end else begin
					rate_tab[w.task_index]     = w.task_rate;
					elapsed_tab[w.task_index]  = w.task_rate;
					slot_written[w.task_index] = 1'b1;
					if (task_total < TASK_SLOTS)
						task_total++;
					queue_reply(KIND_ADDED, w.task_index[2:0], '0);
				end
			end
			OP_TICK: begin
				due_any = 1'b0;
				for (int i = 0; i < task_total; i++) begin
					if (elapsed_tab[i] >= rate_tab[i]) begin
						elapsed_tab[i] = '0;
						runs_tab[i]    = runs_tab[i] + 32'd1;
						queue_reply(KIND_DISPATCH, 3'(i), runs_tab[i]);
						due_any = 1'b1;
					end
					elapsed_tab[i] = elapsed_tab[i] + 32'(step_size);
				end
				if (!due_any)
					queue_reply(KIND_NONE, '0, '0);
			end
			OP_READ: begin
				if (w.task_index >= TASK_SLOTS)
					queue_reply(KIND_REJECT, w.task_index[2:0], '0);
				else
					queue_reply(KIND_COUNT, w.task_index[2:0], runs_tab[w.task_index]);
			end
			default: return;
		endcase
		// the final reply of the word carries the last flag
		tail = expected_replies.pop_back();
		tail.last_reply = 1'b1;
		expected_replies.push_back(tail);
	endfunction

	function automatic void check_reply(input ptd_out_t got);
		ptd_out_t want;
		if (expected_replies.size() == 0) begin
			$error("unexpected reply: kind %0d index %0d count %0d last %0d",
				got.reply_kind, got.reply_index, got.run_count, got.last_reply);
			err_count++;
			return;
		end
		want = expected_replies.pop_front();
		if (got.reply_kind !== want.reply_kind) begin
			$error("reply_kind: expected %0d, got %0d", want.reply_kind, got.reply_kind);
			err_count++;
		end
		if (got.reply_index !== want.reply_index) begin
			$error("reply_index: expected %0d, got %0d", want.reply_index, got.reply_index);
			err_count++;
		end
		if (got.run_count !== want.run_count) begin
			$error("run_count: expected %0d, got %0d", want.run_count, got.run_count);
			err_count++;
		end
		if (got.last_reply !== want.last_reply) begin
			$error("last_reply: expected %0d, got %0d", want.last_reply, got.last_reply);
			err_count++;
		end
	endfunction

	// reply side: check each word taken, then choose ready for the next cycle
	always @(posedge clk) begin
		if (out_valid && out_ready)
			check_reply(out_word);
		if (stall_request != 0) begin
			stall_left = stall_request;
			stall_request = 0;
		end
		if (stall_left != 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// offer one command word and hold it until taken; valid stays up for a follow-on
	task automatic send_cmd(input logic [1:0] op, input logic [7:0] idx,
		input logic [31:0] rate);
		ptd_in_t w;
		w.opcode     = op;
		w.task_index = idx;
		w.task_rate  = rate;
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		predict_replies(w);
		in_valid <= 1'b1;
		in_word  <= w;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain_replies;
		in_valid <= 1'b0;
		while (expected_replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// tick increment is only written with the block idle
	task automatic set_step(input logic [15:0] value);
		drain_replies();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		step_size = value;
	endtask

	task automatic test_commands;
		// empty table: zero count, nothing due, rejects, spare opcode dropped
		send_cmd(OP_READ, 8'd0, '0);
		send_cmd(OP_TICK, 8'd0, '0);
		send_cmd(OP_ADD, 8'd8, 32'hFFFF_FFFF);
		send_cmd(OP_ADD, 8'd255, '0);
		send_cmd(OP_READ, 8'd8, '0);
		send_cmd(OP_READ, 8'd255, '0);
		send_cmd(OP_SPARE, 8'd3, 32'h1234_5678);
		// new tasks are due at once
		send_cmd(OP_ADD, 8'd0, 32'd0);
		send_cmd(OP_ADD, 8'd1, 32'hFFFF_FFFF);
		send_cmd(OP_ADD, 8'd2, 32'd2);
		repeat (3) send_cmd(OP_TICK, 8'd0, '0);
		send_cmd(OP_READ, 8'd1, '0);
		send_cmd(OP_READ, 8'd2, '0);
		// repeated add still raises the task count, so fill the slots it opens
		send_cmd(OP_ADD, 8'd0, 32'd1);
		for (int i = 3; i < TASK_SLOTS; i++)
			send_cmd(OP_ADD, 8'(i), 32'($urandom_range(3)));
		send_cmd(OP_ADD, 8'd5, 32'd0);
		send_cmd(OP_TICK, 8'd0, '0);
		send_cmd(OP_READ, 8'd7, '0);
	endtask

	task automatic test_step_extremes;
		set_step(16'hFFFF);
		repeat (3) send_cmd(OP_TICK, 8'd0, '0);
		// zero increment freezes elapsed times after dispatch
		set_step(16'h0000);
		repeat (3) send_cmd(OP_TICK, 8'd0, '0);
		set_step(16'd1);
		repeat (2) send_cmd(OP_TICK, 8'd0, '0);
	endtask

	task automatic test_backpressure;
		send_idle = 0;
		recv_idle = 0;
		stall_request = 400;
		for (int k = 0; k < 24; k++)
			send_cmd((k % 3 == 0) ? OP_READ : OP_TICK, 8'(k % TASK_SLOTS), '0);
	endtask

	task automatic run_random_phase(input int n);
		int sent;
		int pick;
		logic [1:0] op;
		logic [7:0] idx;
		logic [31:0] rate;
		sent = 0;
		while (sent < n) begin
			pick = $urandom_range(99);
			if ($urandom_range(3) == 0)
				idx = 8'($urandom);
			else
				idx = 8'($urandom_range(TASK_SLOTS - 1));
			// rates mostly a few increments so tasks fall due, sometimes any value
			if ($urandom_range(9) == 0)
				rate = $urandom;
			else
				rate = 32'($urandom_range(6)) * 32'(step_size) + 32'($urandom_range(3));
			if (pick < 30)
				op = OP_ADD;
			else if (pick < 70)
				op = OP_TICK;
			else if (pick < 94)
				op = OP_READ;
			else
				op = OP_SPARE;
			// a tick must not walk a slot whose rate was never set
			if (op == OP_TICK) begin
				for (int i = 0; i < task_total; i++) begin
					if (!slot_written[i]) begin
						op  = OP_ADD;
						idx = 8'(i);
						break;
					end
				end
			end
			send_cmd(op, idx, rate);
			if (op != OP_SPARE)
				sent++;
		end
	endtask

	task automatic test_random;
		set_step(16'($urandom_range(1, 8)));
		send_idle = 24;
		recv_idle = 73;
		run_random_phase(80);
		set_step(16'($urandom_range(1, 65535)));
		send_idle = 73;
		recv_idle = 24;
		run_random_phase(80);
		set_step(16'd1);
		send_idle = 0;
		recv_idle = 0;
		run_random_phase(80);
	endtask

	initial begin
		for (int i = 0; i < TASK_SLOTS; i++) begin
			runs_tab[i]     = '0;
			slot_written[i] = 1'b0;
		end
		task_total = 0;
		step_size  = 16'd1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_commands();
		test_step_extremes();
		test_backpressure();
		test_random();
		drain_replies();
		if (err_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	// watchdog
	initial begin
		#20ms;
		$display("tb: errors");
		$finish;
	end

endmodule

>>> periodic_task_dispatcher_core.f
design/ptd_pkg.sv
design/ptd_ram.sv
design/periodic_task_dispatcher_core.sv
test/tb.sv
